// ===== sv/bse_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded stack engine package
// Item types, command codes and status codes shared by the stack engine and
// its response buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package bse_pkg;

   localparam int CMD_W  = 3;
   localparam int WORD_W = 32;
   localparam int POS_W  = 7;
   localparam int STAT_W = 2;
   localparam int OCC_W  = 7;

   localparam logic [CMD_W-1:0] CMD_PUSH    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP     = 3'd1;
   localparam logic [CMD_W-1:0] CMD_PEEK    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CHANGE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DISPLAY = 3'd4;

   localparam logic [STAT_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_OVERFLOW = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STAT_W-1:0] STATUS_BAD_POS  = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic signed [WORD_W-1:0] value;
      logic [POS_W-1:0]         position;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [WORD_W-1:0] data;
      logic [OCC_W-1:0]         occupancy;
      logic                     last;
   } rsp_type;

endpackage

`default_nettype wire

// ===== sv/bse_rsp_buffer.sv =====
// ----------------------------------------------------------------------------
// Bounded stack engine response buffer
// Two-entry queue that decouples result generation from the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bse_rsp_buffer (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            in_valid,
   output logic                 in_ready,
   input  wire bse_pkg::rsp_type in_data,
   output logic                 out_valid,
   input  wire logic            out_ready,
   output bse_pkg::rsp_type     out_data
);
   import bse_pkg::*;

   rsp_type    head_ff, head_in;
   rsp_type    tail_ff, tail_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = head_ff;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      case (cnt_ff)
         2'd0: begin
            if (push) begin
               head_in = in_data;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = in_data;
            end else if (push) begin
               tail_in = in_data;
               cnt_in  = 2'd2;
            end else if (pop) begin
               cnt_in  = 2'd0;
            end
         end
         default: begin
            // Full: no push is possible here.
            if (pop) begin
               head_in = tail_ff;
               cnt_in  = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

`default_nettype wire

// ===== sv/bounded_stack_engine.sv =====
// ----------------------------------------------------------------------------
// Bounded stack engine
// Last-in first-out store of signed 32-bit words with push, pop, peek,
// change-by-position and display commands.
// ----------------------------------------------------------------------------
// The stack holds up to DEPTH words in a single-port-write, single-port-read
// synchronous memory and serves one request item at a time. Push, change,
// unused command codes and every error case complete in the cycle the item
// is accepted, so such items can follow one another in consecutive cycles
// while the response queue has room. Pop and peek answer from S_READ,
// because the memory read data is registered. Display streams the words held
// from the top of the stack to the bottom, one memory read per cycle while
// the response queue has room, and marks the bottom word as last. Results
// pass through a two-entry response queue, so a stalled response channel
// holds the engine only once that queue is full. No clearing pass is needed
// after reset: only words below the occupancy count are ever read.
`default_nettype none

module bounded_stack_engine #(
   parameter int DEPTH = 64
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire bse_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output bse_pkg::rsp_type      rsp_data
);
   import bse_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   // Sequencer states.
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_READ = 2'd1;
   localparam logic [1:0] S_DISP = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] disp_idx_ff, disp_idx_in;

   // Word store and its ports.
   logic signed [WORD_W-1:0] mem [DEPTH];
   logic signed [WORD_W-1:0] rd_data_ff;
   logic                     rd_en;
   logic [AW-1:0]            rd_addr;
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic signed [WORD_W-1:0] wr_data;

   logic          req_fire;
   logic          res_valid;
   logic          res_ready;
   rsp_type       res;
   logic          full;
   logic          empty;
   logic [CW-1:0] top_idx;
   logic [OCC_W-1:0] count_ext;
   logic [OCC_W-1:0] change_idx;
   logic          pos_ok;
   logic          disp_last;

   assign req_ready  = (state_ff == S_IDLE) && res_ready;
   assign req_fire   = req_valid && req_ready;
   assign full       = (count_ff == CW'(DEPTH));
   assign empty      = (count_ff == '0);
   assign top_idx    = count_ff - CW'(1);
   assign count_ext  = OCC_W'(count_ff);
   // A change position counts from 1 at the top; zero and anything beyond
   // the occupancy are rejected.
   assign pos_ok     = (req_data.position != '0) && (req_data.position <= count_ext);
   assign change_idx = count_ext - req_data.position;
   assign disp_last  = (disp_idx_ff == '0);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      disp_idx_in   = disp_idx_ff;
      rd_en         = 1'b0;
      rd_addr       = top_idx[AW-1:0];
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = req_data.value;
      res_valid     = 1'b0;
      res.status    = STATUS_OK;
      res.data      = req_data.value;
      res.last      = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               unique case (req_data.command)
                  CMD_PUSH: begin
                     res_valid = 1'b1;
                     if (full) begin
                        res.status = STATUS_OVERFLOW;
                        res.data   = '0;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  CMD_POP: begin
                     if (empty) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_EMPTY;
                        res.data   = '0;
                     end else begin
                        rd_en    = 1'b1;
                        count_in = top_idx;
                        state_in = S_READ;
                     end
                  end
                  CMD_PEEK: begin
                     if (empty) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_EMPTY;
                        res.data   = '0;
                     end else begin
                        rd_en    = 1'b1;
                        state_in = S_READ;
                     end
                  end
                  CMD_CHANGE: begin
                     res_valid = 1'b1;
                     if (pos_ok) begin
                        wr_en   = 1'b1;
                        wr_addr = change_idx[AW-1:0];
                     end else begin
                        res.status = STATUS_BAD_POS;
                        res.data   = '0;
                     end
                  end
                  CMD_DISPLAY: begin
                     if (empty) begin
                        res_valid  = 1'b1;
                        res.status = STATUS_EMPTY;
                        res.data   = '0;
                     end else begin
                        rd_en       = 1'b1;
                        disp_idx_in = top_idx[AW-1:0];
                        state_in    = S_DISP;
                     end
                  end
                  default: begin
                     // Unused command codes are consumed without a result.
                  end
               endcase
            end
         end
         S_READ: begin
            // The read data register holds until the queue has room.
            if (res_ready) begin
               res_valid = 1'b1;
               res.data  = rd_data_ff;
               state_in  = S_IDLE;
            end
         end
         S_DISP: begin
            if (res_ready) begin
               res_valid = 1'b1;
               res.data  = rd_data_ff;
               res.last  = disp_last;
               if (disp_last) begin
                  state_in = S_IDLE;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = disp_idx_ff - AW'(1);
                  disp_idx_in = disp_idx_ff - AW'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Occupancy always reports the count after this step.
      res.occupancy = OCC_W'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      disp_idx_ff <= disp_idx_in;
   end

   // A write and a read never happen in the same cycle: writes are issued only
   // for accepted push and change items, reads only for pop, peek and display.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   bse_rsp_buffer u_rsp_buffer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   (res),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   // The occupancy never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset) count_ff <= CW'(DEPTH))
      else $error("stack occupancy beyond capacity");

   // A result is only produced when the response queue can take it.
   assert property (@(posedge clock) disable iff (reset) res_valid |-> res_ready)
      else $error("result produced while response queue full");

   // A successful push raises the occupancy by one.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.command == CMD_PUSH && !full)
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("push did not raise occupancy");

   // A successful pop lowers the occupancy by one and waits for its read.
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_data.command == CMD_POP && !empty)
      |=> (count_ff == $past(count_ff) - CW'(1)) && (state_ff == S_READ))
      else $error("pop did not lower occupancy");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Bounded stack engine testbench
// Drives command items into the stack engine, predicts every result item
// with a behavioural copy of the stack and compares them field by field.
// Runs a directed opening, then random phases under three idling schemes,
// with one long hold-off of the result channel.
// ----------------------------------------------------------------------------

module testbench;

   import bse_pkg::*;

   localparam int STACK_DEPTH   = 64;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int HOLDOFF_SPAN  = 300;
   localparam int SETTLE_CYCLES = 8;

   // Unused command codes: the engine must ignore them and produce nothing.
   localparam logic [CMD_W-1:0] CMD_SPARE_LO  = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_MID = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI  = 3'd7;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   bounded_stack_engine #(
      .DEPTH(STACK_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // Shared testbench state
   // ------------------------------------------------------------------------
   req_type pending_reqs[$];     // command items waiting to be offered
   rsp_type awaited_results[$];  // predicted result items, oldest first

   int  send_idle_pct  = 0;      // chance, per offer, that the sender idles
   int  recv_idle_pct  = 0;      // chance, per cycle, that the receiver idles
   int  holdoffs_asked = 0;      // bumped by the sequence to request a hold-off
   int  cycle_count    = 0;
   bit  req_taken      = 1'b0;   // an item was accepted at the last rising edge
   bit  failed         = 1'b0;

   // Our own copy of the stack: words below stack_fill are live, top at the
   // highest index.
   logic signed [WORD_W-1:0] stack_words[STACK_DEPTH];
   int                       stack_fill = 0;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------

   // Queues one predicted result item; occupancy is taken after the update.
   function automatic void note_result(input logic [STAT_W-1:0] status,
                                       input logic signed [WORD_W-1:0] data,
                                       input logic last);
      rsp_type r;
      r.status    = status;
      r.data      = data;
      r.occupancy = OCC_W'(stack_fill);
      r.last      = last;
      awaited_results.push_back(r);
   endfunction

   // Applies one accepted command to the shadow stack and records the
   // result items that it should produce.
   function automatic void apply_stack_command(input req_type cmd);
      int i;
      case (cmd.command)
         CMD_PUSH: begin
            if (stack_fill >= STACK_DEPTH) begin
               note_result(STATUS_OVERFLOW, '0, 1'b1);
            end else begin
               stack_words[stack_fill] = cmd.value;
               stack_fill++;
               note_result(STATUS_OK, cmd.value, 1'b1);
            end
         end
         CMD_POP: begin
            if (stack_fill == 0) begin
               note_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               stack_fill--;
               note_result(STATUS_OK, stack_words[stack_fill], 1'b1);
            end
         end
         CMD_PEEK: begin
            if (stack_fill == 0) begin
               note_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               note_result(STATUS_OK, stack_words[stack_fill-1], 1'b1);
            end
         end
         CMD_CHANGE: begin
            // Position counts from the top, starting at one; zero and
            // anything beyond the current fill are rejected without a write.
            if (cmd.position == 0 || int'(cmd.position) > stack_fill) begin
               note_result(STATUS_BAD_POS, '0, 1'b1);
            end else begin
               stack_words[stack_fill - int'(cmd.position)] = cmd.value;
               note_result(STATUS_OK, cmd.value, 1'b1);
            end
         end
         CMD_DISPLAY: begin
            // An empty stack still answers, with a single empty-status item.
            if (stack_fill == 0) begin
               note_result(STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (i = 0; i < stack_fill; i++) begin
                  note_result(STATUS_OK, stack_words[stack_fill-1-i],
                              i == stack_fill - 1);
               end
            end
         end
         default: begin
            // Spare codes leave the stack alone and produce no result.
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   function automatic void check_result(input rsp_type got);
      rsp_type want;
      if (awaited_results.size() == 0) begin
         $error("unexpected result item: status %0d data %0d occupancy %0d last %0d",
                got.status, got.data, got.occupancy, got.last);
         failed = 1'b1;
      end else begin
         want = awaited_results.pop_front();
         if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            failed = 1'b1;
         end
         if (got.data !== want.data) begin
            $error("data mismatch: expected %0d, actual %0d", want.data, got.data);
            failed = 1'b1;
         end
         if (got.occupancy !== want.occupancy) begin
            $error("occupancy mismatch: expected %0d, actual %0d",
                   want.occupancy, got.occupancy);
            failed = 1'b1;
         end
         if (got.last !== want.last) begin
            $error("last mismatch: expected %0d, actual %0d", want.last, got.last);
            failed = 1'b1;
         end
      end
   endfunction

   // ------------------------------------------------------------------------
   // Monitor: samples both channels at the rising edge. Acceptances are
   // handled before results, so a result that could appear in the same
   // cycle as its command would still find its prediction waiting.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bounded_stack_engine regression: fail");
         $finish;
      end else if (reset) begin
         req_taken = 1'b0;
      end else begin
         req_taken = req_valid && req_ready;
         if (req_taken) begin
            apply_stack_command(req_data);
         end
         if (rsp_valid && rsp_ready) begin
            check_result(rsp_data);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Driver: moves on to a fresh item only once the current one has been
   // taken, so valid and payload are held steady while the engine stalls.
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random back-pressure, plus a long hold-off counted here when
   // the sequence asks for one. During the hold-off the engine's response
   // queue fills and its request side must stall.
   // ------------------------------------------------------------------------
   int holdoffs_served = 0;
   int holdoff_left    = 0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else if (holdoffs_served != holdoffs_asked) begin
         holdoffs_served = holdoffs_asked;
         holdoff_left    = HOLDOFF_SPAN;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic req_type make_req(input logic [CMD_W-1:0] command,
                                        input logic signed [WORD_W-1:0] value,
                                        input logic [POS_W-1:0] position);
      req_type r;
      r.command  = command;
      r.value    = value;
      r.position = position;
      return r;
   endfunction

   // Draws a random command from a weighted mix (percentages for push, pop,
   // peek, change and display; whatever is left goes to the spare codes).
   function automatic req_type random_request(input int push_pct, input int pop_pct,
                                              input int peek_pct, input int change_pct,
                                              input int display_pct);
      req_type r;
      int      roll;
      roll = $urandom_range(99);
      if (roll < push_pct) begin
         r.command = CMD_PUSH;
      end else if (roll < push_pct + pop_pct) begin
         r.command = CMD_POP;
      end else if (roll < push_pct + pop_pct + peek_pct) begin
         r.command = CMD_PEEK;
      end else if (roll < push_pct + pop_pct + peek_pct + change_pct) begin
         r.command = CMD_CHANGE;
      end else if (roll < push_pct + pop_pct + peek_pct + change_pct + display_pct) begin
         r.command = CMD_DISPLAY;
      end else begin
         r.command = CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
      end
      // Mostly ordinary words, now and then the signed extremes.
      case ($urandom_range(9))
         0:       r.value = 32'sh8000_0000;
         1:       r.value = 32'sh7FFF_FFFF;
         default: r.value = $urandom;
      endcase
      // Positions mostly land within a full stack; the rest roam the whole
      // seven-bit field, zero and out-of-range values included.
      if ($urandom_range(99) < 80) begin
         r.position = POS_W'($urandom_range(STACK_DEPTH, 1));
      end else begin
         r.position = POS_W'($urandom);
      end
      return r;
   endfunction

   // Holds the sequence until every offered item has been taken and every
   // predicted result has arrived, then lets the engine settle.
   task automatic wait_for_drain();
      while (pending_reqs.size() != 0 || req_valid || awaited_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      int n;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening: every command on an empty stack, the word extremes,
      // change at position zero, at the bottom and beyond the fill, the spare
      // codes, and pop down past empty.
      send_idle_pct = 26;
      recv_idle_pct = 49;
      pending_reqs.push_back(make_req(CMD_PEEK,    '0, '0));
      pending_reqs.push_back(make_req(CMD_POP,     '0, '0));
      pending_reqs.push_back(make_req(CMD_DISPLAY, '0, '0));
      pending_reqs.push_back(make_req(CMD_CHANGE,  32'sd9, 7'd1));
      pending_reqs.push_back(make_req(CMD_PUSH,    32'sh8000_0000, '0));
      pending_reqs.push_back(make_req(CMD_PUSH,    32'sh7FFF_FFFF, '0));
      pending_reqs.push_back(make_req(CMD_PUSH,    -32'sd1, '0));
      pending_reqs.push_back(make_req(CMD_PUSH,    32'sd0, 7'h7F));
      pending_reqs.push_back(make_req(CMD_PUSH,    32'sd1, '0));
      pending_reqs.push_back(make_req(CMD_PEEK,    '0, '0));
      pending_reqs.push_back(make_req(CMD_CHANGE,  32'sd7, 7'd0));
      pending_reqs.push_back(make_req(CMD_CHANGE,  32'sh5555_5555, 7'd5));
      pending_reqs.push_back(make_req(CMD_CHANGE,  32'sd3, 7'd6));
      pending_reqs.push_back(make_req(CMD_CHANGE,  32'sd4, 7'd127));
      pending_reqs.push_back(make_req(CMD_CHANGE,  32'shAAAA_AAAA, 7'd1));
      pending_reqs.push_back(make_req(CMD_DISPLAY, '0, '0));
      pending_reqs.push_back(make_req(CMD_SPARE_LO,  32'sd11, 7'd1));
      pending_reqs.push_back(make_req(CMD_SPARE_MID, 32'sd12, 7'd2));
      pending_reqs.push_back(make_req(CMD_SPARE_HI,  32'sd13, 7'd3));
      for (n = 0; n < 6; n++) begin
         pending_reqs.push_back(make_req(CMD_POP, '0, '0));
      end
      wait_for_drain();

      // Push-heavy phase: climbs to a full stack and runs into overflow.
      for (n = 0; n < 100; n++) begin
         pending_reqs.push_back(random_request(80, 5, 5, 5, 3));
      end
      wait_for_drain();

      // Idling swapped. The result channel is held off for a long stretch
      // while commands keep coming, so the engine has to back up.
      send_idle_pct = 49;
      recv_idle_pct = 26;
      holdoffs_asked++;
      for (n = 0; n < 100; n++) begin
         pending_reqs.push_back(random_request(15, 15, 10, 25, 25));
      end
      wait_for_drain();

      // No idling on either side; pop-heavy so the stack shrinks again.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (n = 0; n < 55; n++) begin
         pending_reqs.push_back(random_request(15, 50, 10, 10, 10));
      end
      wait_for_drain();

      if (!failed) begin
         $display("bounded_stack_engine regression: pass");
      end else begin
         $display("bounded_stack_engine regression: fail");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/bse_pkg.sv
sv/bse_rsp_buffer.sv
sv/bounded_stack_engine.sv
verif/testbench.sv
